/* src/point_in_polygon_even_odd_macros.svh */
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd_macros
// Assertion macros used by the checker of the polygon test block.
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_EVEN_ODD_MACROS_SVH
`define POINT_IN_POLYGON_EVEN_ODD_MACROS_SVH

// same-cycle implication, checked out of reset
`define PIP_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define PIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/pipeo_pkg.sv */
// ----------------------------------------------------------------------------
// pipeo_pkg
// Shared widths, codes, types and helpers of the even-odd polygon test.
// ----------------------------------------------------------------------------
package pipeo_pkg;

    // coordinate width inside the datapath, the field itself is 32 bits
    localparam int COORD_BITS  = 32;
    localparam int IN_W        = 32;
    localparam int DIFF_W      = COORD_BITS + 1;
    localparam int PROD_W      = 2 * DIFF_W;

    // stream word widths
    localparam int TDATA_IN_W  = 2 * IN_W;
    localparam int TUSER_IN_W  = 2;
    localparam int TDATA_OUT_W = 8;

    // item kinds
    localparam logic KIND_QUERY  = 1'b0;
    localparam logic KIND_VERTEX = 1'b1;

    typedef logic signed [COORD_BITS-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]     diff_t;
    typedef logic signed [PROD_W-1:0]     prod_t;

    // one edge, (xi, yi) is the newer end of a new edge and the first vertex of a closing edge
    typedef struct packed {
        coord_t xi;
        coord_t yi;
        coord_t xj;
        coord_t yj;
    } edge_t;

    // low COORD_BITS bits of the sign-extended field, read as signed
    function automatic coord_t to_coord(input logic signed [IN_W-1:0] v);
        logic signed [63:0] w;
        w = 64'(v);
        return coord_t'(w[COORD_BITS-1:0]);
    endfunction

endpackage

/* src/point_in_polygon_even_odd.sv */
// ----------------------------------------------------------------------------
// point_in_polygon_even_odd
// Even-odd ray crossing test of a query point against a multi-loop polygon.
// ----------------------------------------------------------------------------
// A query word (kind 0) sets the point and starts a polygon; vertex words
// (kind 1) follow loop by loop, end_of_loop closing a loop and tlast closing
// the polygon, which returns one inside flag. The block takes one word per
// clock unless a result is held at the output by m_tready, and the word that
// ends the polygon passes, once taken, through an input register loaded on the
// accepting edge, a product register holding the exact cross products of the
// new edge and of the closing edge, and the output register where the compares
// fold into the loop and polygon parities. The two 33 by 33 bit products per
// edge set the depth of this chain. While a result waits on m_tready, words that
// end no polygon still pass the inner stages, which fill once a second result
// reaches the product stage.
// ----------------------------------------------------------------------------
module point_in_polygon_even_odd (
    input  logic                              aclk,
    input  logic                              aresetn,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [pipeo_pkg::TDATA_IN_W-1:0]  s_tdata,   // coord_x, coord_y
    input  logic [pipeo_pkg::TUSER_IN_W-1:0]  s_tuser,   // kind, end_of_loop
    input  logic                              s_tlast,   // end_of_polygon
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [pipeo_pkg::TDATA_OUT_W-1:0] m_tdata    // inside_res
);
    import pipeo_pkg::*;

    typedef struct packed {
        logic is_query;
        logic eop;
        logic loop_end;
        logic edge_en;
        logic close_en;
    } ctl_t;

    // input word fields
    logic   in_kind, in_eol, in_eop;
    coord_t in_x, in_y;

    assign in_kind = s_tuser[0];
    assign in_eol  = s_tuser[1];
    assign in_eop  = s_tlast;
    assign in_x    = to_coord($signed(s_tdata[IN_W-1:0]));
    assign in_y    = to_coord($signed(s_tdata[2*IN_W-1:IN_W]));

    // accept-side state
    coord_t qx_reg, qy_reg, qx_next, qy_next;
    coord_t first_x_reg, first_y_reg, first_x_next, first_y_next;
    coord_t prev_x_reg, prev_y_reg, prev_x_next, prev_y_next;
    logic [1:0] cnt_reg, cnt_next;

    // pipeline registers
    logic  v1_reg, v1_next, v2_reg, v2_next;
    ctl_t  ctl1_reg, ctl1_next, ctl2_reg;
    edge_t edge1_reg, edge1_next, close1_reg, close1_next;
    coord_t px1_reg, py1_reg;

    // parities and output
    logic loop_par_reg, loop_par_next, poly_par_reg, poly_par_next;
    logic m_valid_reg, m_valid_next, inside_reg, inside_next;

    logic s_accept, out_free, res2, move1, move2, p2_free;
    logic cross_edge, cross_close;
    logic lp_edge, lp_close, pp_new;

    // flow control: each stage moves when the next one has room
    assign res2     = ctl2_reg.eop;
    assign out_free = !m_valid_reg || m_tready;
    assign move2    = v2_reg && (!res2 || out_free);
    assign p2_free  = !v2_reg || move2;
    assign move1    = v1_reg && p2_free;
    assign s_tready = !v1_reg || move1;
    assign s_accept = s_tvalid && s_tready;

    // loop bookkeeping and stage-one contents
    always_comb begin
        qx_next      = qx_reg;
        qy_next      = qy_reg;
        first_x_next = first_x_reg;
        first_y_next = first_y_reg;
        prev_x_next  = prev_x_reg;
        prev_y_next  = prev_y_reg;
        cnt_next     = cnt_reg;

        ctl1_next.is_query = (in_kind == KIND_QUERY);
        ctl1_next.eop      = in_eop;
        ctl1_next.loop_end = in_eol || in_eop;
        ctl1_next.edge_en  = (in_kind == KIND_VERTEX) && (cnt_reg != 2'd0);
        ctl1_next.close_en = (in_kind == KIND_VERTEX) && (in_eol || in_eop) &&
                             (cnt_reg >= 2'd2);
        edge1_next  = '{xi: in_x, yi: in_y, xj: prev_x_reg, yj: prev_y_reg};
        close1_next = '{xi: first_x_reg, yi: first_y_reg, xj: in_x, yj: in_y};

        if (s_accept) begin
            if (in_kind == KIND_QUERY) begin
                qx_next  = in_x;
                qy_next  = in_y;
                cnt_next = 2'd0;
            end else begin
                if (cnt_reg == 2'd0) begin
                    first_x_next = in_x;
                    first_y_next = in_y;
                end
                if (cnt_reg != 2'd3) begin
                    cnt_next = cnt_reg + 2'd1;
                end
                prev_x_next = in_x;
                prev_y_next = in_y;
                if (in_eol || in_eop) begin
                    cnt_next = 2'd0;
                end
            end
        end
    end

    // stage valids
    always_comb begin
        v1_next = v1_reg;
        if (s_accept) begin
            v1_next = 1'b1;
        end else if (move1) begin
            v1_next = 1'b0;
        end
        v2_next = v2_reg;
        if (move1) begin
            v2_next = 1'b1;
        end else if (move2) begin
            v2_next = 1'b0;
        end
    end

    // accept-side and stage-one registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg  <= '0;
            qy_reg  <= '0;
            cnt_reg <= 2'd0;
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
        end else begin
            qx_reg  <= qx_next;
            qy_reg  <= qy_next;
            cnt_reg <= cnt_next;
            v1_reg  <= v1_next;
            v2_reg  <= v2_next;
        end
    end

    always_ff @(posedge aclk) begin
        first_x_reg <= first_x_next;
        first_y_reg <= first_y_next;
        prev_x_reg  <= prev_x_next;
        prev_y_reg  <= prev_y_next;
        if (s_accept) begin
            ctl1_reg   <= ctl1_next;
            edge1_reg  <= edge1_next;
            close1_reg <= close1_next;
            px1_reg    <= qx_reg;
            py1_reg    <= qy_reg;
        end
        if (move1) begin
            ctl2_reg <= ctl1_reg;
        end
    end

    // product stage for the new edge and the closing edge
    pipeo_cross u_cross_edge (
        .aclk    (aclk),
        .load    (move1),
        .edge_i  (edge1_reg),
        .px_i    (px1_reg),
        .py_i    (py1_reg),
        .cross_o (cross_edge)
    );

    pipeo_cross u_cross_close (
        .aclk    (aclk),
        .load    (move1),
        .edge_i  (close1_reg),
        .px_i    (px1_reg),
        .py_i    (py1_reg),
        .cross_o (cross_close)
    );

    // parity folding and result
    always_comb begin
        lp_edge  = loop_par_reg ^ (ctl2_reg.edge_en && cross_edge);
        lp_close = lp_edge ^ (ctl2_reg.close_en && cross_close);
        pp_new   = poly_par_reg ^ (ctl2_reg.close_en && lp_close);

        loop_par_next = loop_par_reg;
        poly_par_next = poly_par_reg;
        inside_next   = inside_reg;
        if (move2) begin
            if (ctl2_reg.is_query) begin
                loop_par_next = 1'b0;
                poly_par_next = 1'b0;
                inside_next   = 1'b0;
            end else begin
                loop_par_next = ctl2_reg.loop_end ? 1'b0 : lp_close;
                poly_par_next = ctl2_reg.eop ? 1'b0 : pp_new;
                inside_next   = pp_new;
            end
        end

        m_valid_next = m_valid_reg;
        if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
        if (move2 && res2) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loop_par_reg <= 1'b0;
            poly_par_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            loop_par_reg <= loop_par_next;
            poly_par_reg <= poly_par_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (move2 && res2) begin
            inside_reg <= inside_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(TDATA_OUT_W-1){1'b0}}, inside_reg};

endmodule

/* src/pipeo_cross.sv */
// ----------------------------------------------------------------------------
// pipeo_cross
// Ray crossing test of one edge: straddle check and two exact products,
// registered, then a signed compare of the products.
// ----------------------------------------------------------------------------
module pipeo_cross (
    input  logic             aclk,
    input  logic             load,
    input  pipeo_pkg::edge_t edge_i,
    input  pipeo_pkg::coord_t px_i,
    input  pipeo_pkg::coord_t py_i,
    output logic             cross_o
);
    import pipeo_pkg::*;

    diff_t u, dx, dy, t;
    logic  straddle_next, dy_neg_next;
    prod_t lhs_next, rhs_next;

    logic  straddle_reg, dy_neg_reg;
    prod_t lhs_reg, rhs_reg;

    // differences, straddle and the two cross products
    always_comb begin
        u  = diff_t'(px_i) - diff_t'(edge_i.xi);
        dx = diff_t'(edge_i.xj) - diff_t'(edge_i.xi);
        dy = diff_t'(edge_i.yj) - diff_t'(edge_i.yi);
        t  = diff_t'(py_i) - diff_t'(edge_i.yi);
        straddle_next = (edge_i.yi > py_i) != (edge_i.yj > py_i);
        dy_neg_next   = dy[DIFF_W-1];
        lhs_next      = prod_t'(u) * prod_t'(dy);
        rhs_next      = prod_t'(dx) * prod_t'(t);
    end

    // product stage
    always_ff @(posedge aclk) begin
        if (load) begin
            straddle_reg <= straddle_next;
            dy_neg_reg   <= dy_neg_next;
            lhs_reg      <= lhs_next;
            rhs_reg      <= rhs_next;
        end
    end

    // crossing to the right of the point, direction by the sign of dy
    assign cross_o = straddle_reg &&
                     (dy_neg_reg ? (rhs_reg < lhs_reg) : (lhs_reg < rhs_reg));

endmodule

/* src/pipeo_checker.sv */
// ----------------------------------------------------------------------------
// pipeo_checker
// Port-level checks of the polygon test block, bound to its top level.
// ----------------------------------------------------------------------------
`include "point_in_polygon_even_odd_macros.svh"

module pipeo_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [pipeo_pkg::TDATA_IN_W-1:0]  s_tdata,
    input logic [pipeo_pkg::TUSER_IN_W-1:0]  s_tuser,
    input logic                              s_tlast,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [pipeo_pkg::TDATA_OUT_W-1:0] m_tdata
);
    import pipeo_pkg::*;

    // a stalled result word stays put
    `PIP_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result word changed while stalled")

    // only the flag bit of the result word is ever set
    `PIP_ASSERT_IMPL(a_out_pad, aclk, aresetn, m_tvalid, m_tdata[TDATA_OUT_W-1:1] == '0, "result padding not zero")

    // with no result waiting the pipeline never holds off the input
    `PIP_ASSERT_IMPL(a_in_ready, aclk, aresetn, !m_tvalid, s_tready, "input stalled with empty output")

endmodule

bind point_in_polygon_even_odd pipeo_checker u_pipeo_checker (.*);
